### rtl/core/uvs_pkg.sv
package uvs_pkg;

    // Fixed field widths
    localparam int IDX_W     = 17;
    localparam int CFG_W     = 9;
    localparam int REG_IDX_W = 1;

    // Register reset values and lower limits
    localparam int WIDTH_RESET  = 64;
    localparam int HEIGHT_RESET = 32;
    localparam int W_MIN        = 3;
    localparam int H_MIN        = 2;

    // Configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // Kind of grid cell: cap-row cells emit one triangle, middle-row cells two
    typedef enum logic [1:0] {
        CELL_TOP = 2'd0,
        CELL_MID = 2'd1,
        CELL_BOT = 2'd2
    } t_cell_kind;

    // Cell descriptor handed from the walk to the index sequencer
    typedef struct packed {
        logic [IDX_W-1:0] v;          // upper-left vertex
        logic [IDX_W-1:0] n;          // same column, next row
        t_cell_kind       kind;
        logic             mesh_last;  // final cell of the sphere
    } t_cell;

endpackage

### rtl/core/uv_sphere_index_generator.sv
// Triangle index generator for a UV sphere of (W+1)*(H+1) vertices. Each input beat
// takes one grid cell, row by row (restart jumps to cell (0,0)), and yields the
// cell's corner indices one beat per cycle while the output is not stalled: three
// for a pole-cap cell, six for a middle cell. The single output register is the
// limit; the next cell is accepted in the same cycle as the previous cell's last
// index moves, so the output runs without gaps. The first index of a cell passes
// through the cell register and then the output register. A write to either
// register also resets the walk to cell (0,0); out-of-range sizes are clamped.
module uv_sphere_index_generator #(
    parameter int MAX_WIDTH_SEGMENTS  = 256,
    parameter int MAX_HEIGHT_SEGMENTS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [uvs_pkg::REG_IDX_W-1:0]   i_cfg_index,
    input  logic [uvs_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_restart,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [uvs_pkg::IDX_W-1:0]       o_vertex_index,
    output logic                            o_cell_last,
    output logic                            o_mesh_last
);
    import uvs_pkg::*;

    localparam int W_CAP  = (MAX_WIDTH_SEGMENTS < 511) ? MAX_WIDTH_SEGMENTS : 511;
    localparam int H_CAP  = (MAX_HEIGHT_SEGMENTS < 511) ? MAX_HEIGHT_SEGMENTS : 511;
    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] SLOT_LAST_CAP = SLOT_W'(2);
    localparam logic [SLOT_W-1:0] SLOT_LAST_MID = SLOT_W'(5);

    typedef enum logic [1:0] {
        CORNER_V  = 2'd0,
        CORNER_V1 = 2'd1,
        CORNER_N  = 2'd2,
        CORNER_N1 = 2'd3
    } t_corner;

    logic [CFG_W-1:0]  r_width, r_height;
    logic [CFG_W-1:0]  w_eff, h_eff;
    logic              cfg_hit;
    t_cell             cell_next;
    t_cell             r_cell;
    logic              r_cell_valid;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    logic [IDX_W-1:0]  r_vertex_index;
    logic              r_cell_last, r_mesh_last;
    logic              out_load, emit, slot_last, in_acc;
    logic [IDX_W-1:0]  idx;
    t_corner           corner;

    // Corner order per cell kind
    function automatic t_corner pick_corner(t_cell_kind k, logic [SLOT_W-1:0] s);
        t_corner c;
        c = CORNER_V;
        unique case (k)
            CELL_TOP: begin
                unique case (s)
                    3'd0:    c = CORNER_V;
                    3'd1:    c = CORNER_N1;
                    default: c = CORNER_N;
                endcase
            end
            CELL_BOT: begin
                unique case (s)
                    3'd0:    c = CORNER_N;
                    3'd1:    c = CORNER_V;
                    default: c = CORNER_V1;
                endcase
            end
            default: begin
                unique case (s)
                    3'd0:    c = CORNER_V;
                    3'd1:    c = CORNER_V1;
                    3'd2:    c = CORNER_N;
                    3'd3:    c = CORNER_N;
                    3'd4:    c = CORNER_V1;
                    default: c = CORNER_N1;
                endcase
            end
        endcase
        return c;
    endfunction

    // Configuration registers
    assign cfg_hit = i_cfg_we && ((i_cfg_index == REG_WIDTH) || (i_cfg_index == REG_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(WIDTH_RESET);
            r_height <= CFG_W'(HEIGHT_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_index == REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Clamp sizes into the supported range
    always_comb begin
        w_eff = r_width;
        if (r_width < CFG_W'(W_MIN)) begin
            w_eff = CFG_W'(W_MIN);
        end else if (r_width > CFG_W'(W_CAP)) begin
            w_eff = CFG_W'(W_CAP);
        end
        h_eff = r_height;
        if (r_height < CFG_W'(H_MIN)) begin
            h_eff = CFG_W'(H_MIN);
        end else if (r_height > CFG_W'(H_CAP)) begin
            h_eff = CFG_W'(H_CAP);
        end
    end

    uvs_walk #(
        .MAX_WIDTH_SEGMENTS  (MAX_WIDTH_SEGMENTS),
        .MAX_HEIGHT_SEGMENTS (MAX_HEIGHT_SEGMENTS)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (in_acc),
        .i_restart (i_restart),
        .i_home    (cfg_hit),
        .i_width   (w_eff),
        .i_height  (h_eff),
        .o_cell    (cell_next)
    );

    // Handshake: cell register frees as its last index moves out
    assign out_load   = !r_out_valid || i_out_ready;
    assign emit       = r_cell_valid && out_load;
    assign slot_last  = (r_cell.kind == CELL_MID) ? (r_slot == SLOT_LAST_MID)
                                                  : (r_slot == SLOT_LAST_CAP);
    assign o_in_ready = !r_cell_valid || (emit && slot_last);
    assign in_acc     = i_in_valid && o_in_ready;

    // Index for the current slot
    always_comb begin
        corner = pick_corner(r_cell.kind, r_slot);
        unique case (corner)
            CORNER_V:  idx = r_cell.v;
            CORNER_V1: idx = r_cell.v + IDX_W'(1);
            CORNER_N:  idx = r_cell.n;
            default:   idx = r_cell.n + IDX_W'(1);
        endcase
    end

    // Cell register and slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid <= 1'b0;
            r_slot       <= '0;
        end else if (in_acc) begin
            r_cell_valid <= 1'b1;
            r_slot       <= '0;
        end else if (emit) begin
            r_cell_valid <= !slot_last;
            r_slot       <= r_slot + SLOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cell <= cell_next;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_vertex_index <= idx;
            r_cell_last    <= slot_last;
            r_mesh_last    <= r_cell.mesh_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_vertex_index;
    assign o_cell_last    = r_cell_last;
    assign o_mesh_last    = r_mesh_last;

endmodule

### rtl/core/uvs_walk.sv
module uvs_walk #(
    parameter int MAX_WIDTH_SEGMENTS  = 256,
    parameter int MAX_HEIGHT_SEGMENTS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic                        i_restart,
    input  logic                        i_home,
    input  logic [uvs_pkg::CFG_W-1:0]   i_width,
    input  logic [uvs_pkg::CFG_W-1:0]   i_height,
    output uvs_pkg::t_cell              o_cell
);
    import uvs_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH_SEGMENTS);
    localparam int RW    = $clog2(MAX_HEIGHT_SEGMENTS);
    localparam int CMP_C = ((CW > CFG_W) ? CW : CFG_W) + 1;
    localparam int CMP_R = ((RW > CFG_W) ? RW : CFG_W) + 1;

    logic [CW-1:0]    r_col, n_col, col;
    logic [RW-1:0]    r_row, n_row, row;
    logic [IDX_W-1:0] r_base, n_base, base;
    logic [IDX_W-1:0] w_plus1;
    logic             last_col, last_row;

    // Current cell, with restart folded in
    always_comb begin
        col  = i_restart ? '0 : r_col;
        row  = i_restart ? '0 : r_row;
        base = i_restart ? '0 : r_base;

        w_plus1  = IDX_W'(i_width) + IDX_W'(1);
        last_col = (CMP_C'(col) + CMP_C'(1)) >= CMP_C'(i_width);
        last_row = (CMP_R'(row) + CMP_R'(1)) >= CMP_R'(i_height);

        o_cell.v         = base + IDX_W'(col);
        o_cell.n         = o_cell.v + w_plus1;
        o_cell.mesh_last = last_col && last_row;
        if (row == '0) begin
            o_cell.kind = CELL_TOP;
        end else if (last_row) begin
            o_cell.kind = CELL_BOT;
        end else begin
            o_cell.kind = CELL_MID;
        end
    end

    // Advance to the next cell, wrap after the final one
    always_comb begin
        priority if (!last_col) begin
            n_col  = col + CW'(1);
            n_row  = row;
            n_base = base;
        end else if (!last_row) begin
            n_col  = '0;
            n_row  = row + RW'(1);
            n_base = base + w_plus1;
        end else begin
            n_col  = '0;
            n_row  = '0;
            n_base = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_home) begin
            r_col  <= '0;
            r_row  <= '0;
            r_base <= '0;
        end else if (i_step) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_base <= n_base;
        end
    end

endmodule

### rtl/core/uvs_checker.sv
module uvs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [uvs_pkg::IDX_W-1:0]  o_vertex_index,
    input logic                       o_cell_last,
    input logic                       o_mesh_last
);
    import uvs_pkg::*;

    logic out_beat;
    assign out_beat = o_out_valid && i_out_ready;

    // Output beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_vertex_index)
                                        && $stable(o_cell_last) && $stable(o_mesh_last))
        else $error("output beat dropped or changed while stalled");

    // Indices of a cell stream back to back
    a_cell_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !o_cell_last |=> o_out_valid)
        else $error("gap inside a cell");

    // Final-cell flag constant across a cell
    a_mesh_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !o_cell_last |=> o_mesh_last == $past(o_mesh_last))
        else $error("mesh_last changed inside a cell");

    // Nothing pending after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind uv_sphere_index_generator uvs_checker u_uvs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_vertex_index (o_vertex_index),
    .o_cell_last    (o_cell_last),
    .o_mesh_last    (o_mesh_last)
);
